// ===== rtl/core/gaussian_blur_5tap_rgb_pass_defines.svh =====
// ---------------------------------------------------------------------------
// gaussian_blur_5tap_rgb_pass_defines
// assertion macros shared by the blur checker
// ---------------------------------------------------------------------------
`ifndef GAUSSIAN_BLUR_5TAP_RGB_PASS_DEFINES_SVH
`define GAUSSIAN_BLUR_5TAP_RGB_PASS_DEFINES_SVH

// same-cycle implication, masked while in reset
`define GBLUR_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, masked while in reset
`define GBLUR_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

// next-cycle implication that also holds across reset
`define GBLUR_ASSERT_RST(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/gblur_pkg.sv =====
// ---------------------------------------------------------------------------
// gblur_pkg
// shared types and constants of the 5-tap rgb blur pass
// ---------------------------------------------------------------------------
package gblur_pkg;

    // geometry
    localparam int DEF_MAX_WIDTH = 2048;
    localparam int MAX_HEIGHT    = 2048;
    localparam int MIN_DIM       = 5;
    localparam int EDGE          = 2;
    localparam int DIM_W         = 12;
    localparam int ROW_W         = 11;
    localparam int HGT_W         = DIM_W + 1;

    // arithmetic
    localparam int COEF_FRAC_BITS = 14;
    localparam int COEF_W         = 16;
    localparam int CHAN_W         = 8;
    localparam int NUM_CHAN       = 3;
    localparam int PIX_W          = CHAN_W * NUM_CHAN;
    localparam int PROD_W         = COEF_W + CHAN_W + 2;
    localparam int SUM_W          = PROD_W + 2;
    localparam int PIX_MAX        = 255;

    // window and line store
    localparam int NUM_TAPS   = 5;
    localparam int NUM_LINES  = 4;
    localparam int LINE_SEL_W = 2;

    // results per beat group
    localparam int MAX_RESULTS = 3;
    localparam int CNT_W       = 2;
    localparam int Q_DEPTH     = 4;

    // register port
    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;

    localparam logic [DIM_W-1:0]         RST_WIDTH  = 12'd640;
    localparam logic [DIM_W-1:0]         RST_HEIGHT = 12'd480;
    localparam logic signed [COEF_W-1:0] RST_CENTER = 16'sd6144;
    localparam logic signed [COEF_W-1:0] RST_NEAR   = 16'sd4096;
    localparam logic signed [COEF_W-1:0] RST_FAR    = 16'sd1024;

    typedef enum logic [2:0] {
        REG_DIRECTION   = 3'd0,
        REG_WIDTH       = 3'd1,
        REG_HEIGHT      = 3'd2,
        REG_COEF_CENTER = 3'd3,
        REG_COEF_NEAR   = 3'd4,
        REG_COEF_FAR    = 3'd5
    } reg_idx_t;

    // channel 0 is red, in the lowest bits
    typedef logic [NUM_CHAN-1:0][CHAN_W-1:0] pixel_t;

    typedef struct packed {
        logic                      direction;
        logic [DIM_W-1:0]          width_pixels;
        logic [DIM_W-1:0]          height_rows;
        logic signed [COEF_W-1:0]  coef_center;
        logic signed [COEF_W-1:0]  coef_near;
        logic signed [COEF_W-1:0]  coef_far;
    } cfg_t;

    // taps and side pixels of the item held in the window stage
    typedef struct packed {
        pixel_t [NUM_TAPS-1:0] tap;
        pixel_t                extra_a;
        pixel_t                extra_b;
        logic                  first_en;
        logic                  extra_en;
        logic                  interior;
    } tap_t;

    // all beats caused by one input pixel
    typedef struct packed {
        pixel_t [MAX_RESULTS-1:0] px;
        logic [CNT_W-1:0]         cnt;
    } item_t;

endpackage

// ===== rtl/core/gblur_regs.sv =====
// ---------------------------------------------------------------------------
// gblur_regs
// apb register file holding direction, image size and tap weights
// ---------------------------------------------------------------------------
module gblur_regs (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [gblur_pkg::ADDR_W-1:0]  paddr,
    input  logic [gblur_pkg::DATA_W-1:0]  pwdata,
    output logic [gblur_pkg::DATA_W-1:0]  prdata,
    output logic                          pready,
    output gblur_pkg::cfg_t               cfg
);
    import gblur_pkg::*;

    cfg_t     cfg_reg;
    cfg_t     cfg_next;
    reg_idx_t idx;
    logic     wr_en;

    assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;
    assign cfg    = cfg_reg;

    // write decode
    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            unique case (idx)
                REG_DIRECTION:   cfg_next.direction    = pwdata[0];
                REG_WIDTH:       cfg_next.width_pixels = pwdata[DIM_W-1:0];
                REG_HEIGHT:      cfg_next.height_rows  = pwdata[DIM_W-1:0];
                REG_COEF_CENTER: cfg_next.coef_center  = pwdata[COEF_W-1:0];
                REG_COEF_NEAR:   cfg_next.coef_near    = pwdata[COEF_W-1:0];
                REG_COEF_FAR:    cfg_next.coef_far     = pwdata[COEF_W-1:0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    // read mux
    always_comb begin
        unique case (idx)
            REG_DIRECTION:   prdata = {{(DATA_W-1){1'b0}}, cfg_reg.direction};
            REG_WIDTH:       prdata = {{(DATA_W-DIM_W){1'b0}}, cfg_reg.width_pixels};
            REG_HEIGHT:      prdata = {{(DATA_W-DIM_W){1'b0}}, cfg_reg.height_rows};
            REG_COEF_CENTER: prdata = {{(DATA_W-COEF_W){1'b0}}, cfg_reg.coef_center};
            REG_COEF_NEAR:   prdata = {{(DATA_W-COEF_W){1'b0}}, cfg_reg.coef_near};
            REG_COEF_FAR:    prdata = {{(DATA_W-COEF_W){1'b0}}, cfg_reg.coef_far};
            default:         prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.direction    <= 1'b0;
            cfg_reg.width_pixels <= RST_WIDTH;
            cfg_reg.height_rows  <= RST_HEIGHT;
            cfg_reg.coef_center  <= RST_CENTER;
            cfg_reg.coef_near    <= RST_NEAR;
            cfg_reg.coef_far     <= RST_FAR;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// ===== rtl/core/gblur_ram.sv =====
// ---------------------------------------------------------------------------
// gblur_ram
// simple dual-port ram, one write and one registered read per cycle
// ---------------------------------------------------------------------------
module gblur_ram #(
    parameter int WIDTH = gblur_pkg::PIX_W,
    parameter int DEPTH = gblur_pkg::DEF_MAX_WIDTH
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    assign rd_data = rd_data_reg;

    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

endmodule

// ===== rtl/core/gblur_window.sv =====
// ---------------------------------------------------------------------------
// gblur_window
// input stage: raster counters, pixel window and four line stores
// ---------------------------------------------------------------------------
module gblur_window #(
    parameter int MAX_WIDTH = gblur_pkg::DEF_MAX_WIDTH
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  gblur_pkg::cfg_t   cfg,
    input  logic              s_valid,
    input  gblur_pkg::pixel_t s_pixel,
    output logic              s_ready,
    input  logic              take,
    output logic              tap_valid,
    output gblur_pkg::tap_t   taps
);
    import gblur_pkg::*;

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int WID_W = $clog2(MAX_WIDTH + 1);
    localparam int LIM_W = ((WID_W > DIM_W) ? WID_W : DIM_W) + 1;

    logic [COL_W-1:0]      col_reg, col_next;
    logic [ROW_W-1:0]      row_reg, row_next;
    pixel_t [NUM_TAPS-1:0] win_reg;

    logic                  s1_valid_reg;
    logic [COL_W-1:0]      s1_col_reg;
    logic [LINE_SEL_W-1:0] s1_line_reg;
    logic                  s1_first_reg;
    logic                  s1_extra_reg;
    logic                  s1_interior_reg;

    logic [LIM_W-1:0]      w_raw, w_lim, col_ext;
    logic [HGT_W-1:0]      h_raw, h_lim, row_ext;
    logic                  last_col, last_row;
    logic                  first_en, extra_en, interior;
    logic                  acc;

    pixel_t [NUM_LINES-1:0] line_rd;
    logic [NUM_LINES-1:0]   line_we;
    logic [LINE_SEL_W-1:0]  line_sel [NUM_LINES];

    assign s_ready   = !s1_valid_reg || take;
    assign acc       = s_valid && s_ready;
    assign tap_valid = s1_valid_reg;

    // image size limited to the supported range
    always_comb begin
        w_raw = LIM_W'(cfg.width_pixels);
        if (w_raw < LIM_W'(MIN_DIM)) begin
            w_lim = LIM_W'(MIN_DIM);
        end else if (w_raw > LIM_W'(MAX_WIDTH)) begin
            w_lim = LIM_W'(MAX_WIDTH);
        end else begin
            w_lim = w_raw;
        end
        h_raw = HGT_W'(cfg.height_rows);
        if (h_raw < HGT_W'(MIN_DIM)) begin
            h_lim = HGT_W'(MIN_DIM);
        end else if (h_raw > HGT_W'(MAX_HEIGHT)) begin
            h_lim = HGT_W'(MAX_HEIGHT);
        end else begin
            h_lim = h_raw;
        end
    end

    // position flags of the arriving pixel
    assign col_ext  = LIM_W'(col_reg);
    assign row_ext  = HGT_W'(row_reg);
    assign last_col = (col_ext + LIM_W'(1)) >= w_lim;
    assign last_row = (row_ext + HGT_W'(1)) >= h_lim;

    always_comb begin
        if (cfg.direction) begin
            first_en = row_ext >= HGT_W'(EDGE);
            extra_en = last_row;
            interior = (col_ext >= LIM_W'(EDGE))
                    && ((col_ext + LIM_W'(EDGE + 1)) <= w_lim)
                    && (row_ext >= HGT_W'(2 * EDGE))
                    && (row_ext < h_lim);
        end else begin
            first_en = col_ext >= LIM_W'(EDGE);
            extra_en = last_col;
            interior = (col_ext >= LIM_W'(2 * EDGE))
                    && (col_ext < w_lim)
                    && (row_ext >= HGT_W'(EDGE))
                    && ((row_ext + HGT_W'(EDGE + 1)) <= h_lim);
        end
    end

    // raster counters
    always_comb begin
        col_next = col_reg;
        row_next = row_reg;
        if (acc) begin
            if (last_col) begin
                col_next = '0;
                row_next = last_row ? '0 : row_reg + ROW_W'(1);
            end else begin
                col_next = col_reg + COL_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg      <= '0;
            row_reg      <= '0;
            win_reg      <= '0;
            s1_valid_reg <= 1'b0;
        end else begin
            col_reg <= col_next;
            row_reg <= row_next;
            if (acc) begin
                win_reg      <= {win_reg[NUM_TAPS-2:0], s_pixel};
                s1_valid_reg <= 1'b1;
            end else if (take) begin
                s1_valid_reg <= 1'b0;
            end
        end
    end

    // side information of the held item
    always_ff @(posedge aclk) begin
        if (acc) begin
            s1_col_reg      <= col_reg;
            s1_line_reg     <= row_reg[LINE_SEL_W-1:0];
            s1_first_reg    <= first_en;
            s1_extra_reg    <= extra_en;
            s1_interior_reg <= interior;
        end
    end

    // four line stores, read on accept, written in direction 1 when the item moves on
    for (genvar i = 0; i < NUM_LINES; i++) begin : g_line
        assign line_we[i]  = s1_valid_reg && take && cfg.direction
                          && (s1_line_reg == LINE_SEL_W'(i));
        assign line_sel[i] = s1_line_reg + LINE_SEL_W'(i);

        gblur_ram #(
            .WIDTH (PIX_W),
            .DEPTH (MAX_WIDTH)
        ) u_line (
            .clk     (aclk),
            .wr_en   (line_we[i]),
            .wr_addr (s1_col_reg),
            .wr_data (win_reg[0]),
            .rd_en   (acc),
            .rd_addr (col_reg),
            .rd_data (line_rd[i])
        );
    end

    // tap selection: along the row from the window, along the column from the lines
    always_comb begin
        taps.first_en = s1_first_reg;
        taps.extra_en = s1_extra_reg;
        taps.interior = s1_interior_reg;
        taps.extra_b  = win_reg[0];
        if (cfg.direction) begin
            for (int i = 0; i < NUM_LINES; i++) begin
                taps.tap[i] = line_rd[line_sel[i]];
            end
            taps.tap[NUM_TAPS-1] = win_reg[0];
            taps.extra_a         = line_rd[line_sel[NUM_LINES-1]];
        end else begin
            for (int i = 0; i < NUM_TAPS; i++) begin
                taps.tap[i] = win_reg[NUM_TAPS-1-i];
            end
            taps.extra_a = win_reg[1];
        end
    end

endmodule

// ===== rtl/core/gblur_filter.sv =====
// ---------------------------------------------------------------------------
// gblur_filter
// symmetric pre-add and multiply, then sum, clamp and beat assembly
// ---------------------------------------------------------------------------
module gblur_filter (
    input  logic             aclk,
    input  logic             aresetn,
    input  gblur_pkg::cfg_t  cfg,
    input  logic             tap_valid,
    input  gblur_pkg::tap_t  taps,
    output logic             take,
    input  logic             q_full,
    output logic             push,
    output gblur_pkg::item_t item
);
    import gblur_pkg::*;

    logic [CHAN_W:0]          pre_outer [NUM_CHAN];
    logic [CHAN_W:0]          pre_inner [NUM_CHAN];
    logic signed [PROD_W-1:0] prod_next [NUM_CHAN][3];

    logic                     s2_valid_reg;
    logic signed [PROD_W-1:0] prod_reg [NUM_CHAN][3];
    pixel_t                   pass_reg;
    pixel_t                   extra_a_reg;
    pixel_t                   extra_b_reg;
    logic                     first_reg;
    logic                     extra_reg;
    logic                     interior_reg;

    logic signed [SUM_W-1:0]  tot [NUM_CHAN];
    logic [SUM_W-1:0]         shifted [NUM_CHAN];
    pixel_t                   filt_px;
    pixel_t                   res0;
    logic [CNT_W-1:0]         cnt;
    logic                     stall;

    // pre-add mirrored taps, one multiply per weight and channel
    always_comb begin
        for (int c = 0; c < NUM_CHAN; c++) begin
            pre_outer[c] = {1'b0, taps.tap[0][c]} + {1'b0, taps.tap[4][c]};
            pre_inner[c] = {1'b0, taps.tap[1][c]} + {1'b0, taps.tap[3][c]};
            prod_next[c][0] = $signed(cfg.coef_far) * $signed({1'b0, pre_outer[c]});
            prod_next[c][1] = $signed(cfg.coef_near) * $signed({1'b0, pre_inner[c]});
            prod_next[c][2] = $signed(cfg.coef_center) * $signed({2'b00, taps.tap[2][c]});
        end
    end

    // stage hand-off
    assign cnt   = {extra_reg, first_reg};
    assign stall = s2_valid_reg && (cnt != '0) && q_full;
    assign take  = !stall;
    assign push  = s2_valid_reg && (cnt != '0) && !q_full;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg <= 1'b0;
        end else if (take) begin
            s2_valid_reg <= tap_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (take && tap_valid) begin
            prod_reg     <= prod_next;
            pass_reg     <= taps.tap[2];
            extra_a_reg  <= taps.extra_a;
            extra_b_reg  <= taps.extra_b;
            first_reg    <= taps.first_en;
            extra_reg    <= taps.extra_en;
            interior_reg <= taps.interior;
        end
    end

    // sum, drop fraction, clamp to 0..255
    always_comb begin
        for (int c = 0; c < NUM_CHAN; c++) begin
            tot[c] = SUM_W'(prod_reg[c][0]) + SUM_W'(prod_reg[c][1])
                   + SUM_W'(prod_reg[c][2]);
            shifted[c] = tot[c] >>> COEF_FRAC_BITS;
            if (tot[c][SUM_W-1] || (tot[c] == '0)) begin
                filt_px[c] = '0;
            end else if (|shifted[c][SUM_W-1:CHAN_W]) begin
                filt_px[c] = CHAN_W'(PIX_MAX);
            end else begin
                filt_px[c] = shifted[c][CHAN_W-1:0];
            end
        end
    end

    // beats of this pixel, in order
    assign res0 = interior_reg ? filt_px : pass_reg;

    always_comb begin
        item.cnt   = cnt;
        item.px[0] = first_reg ? res0 : extra_a_reg;
        item.px[1] = first_reg ? extra_a_reg : extra_b_reg;
        item.px[2] = extra_b_reg;
    end

endmodule

// ===== rtl/core/gblur_outq.sv =====
// ---------------------------------------------------------------------------
// gblur_outq
// result queue: one entry per pixel with output, unpacked into one to three beats
// ---------------------------------------------------------------------------
module gblur_outq (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        push,
    input  gblur_pkg::item_t            item,
    output logic                        full,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [gblur_pkg::PIX_W-1:0] m_tdata,
    output logic                        m_tlast
);
    import gblur_pkg::*;

    localparam int PTR_W   = $clog2(Q_DEPTH);
    localparam int LEVEL_W = $clog2(Q_DEPTH + 1);

    item_t              q_reg [Q_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [LEVEL_W-1:0] level_reg;
    logic [CNT_W-1:0]   sub_reg;
    item_t              head;
    logic               beat, pop;

    assign head     = q_reg[rd_ptr_reg];
    assign full     = level_reg == LEVEL_W'(Q_DEPTH);
    assign m_tvalid = level_reg != '0;
    assign m_tdata  = head.px[sub_reg];
    assign m_tlast  = (sub_reg + CNT_W'(1)) == head.cnt;
    assign beat     = m_tvalid && m_tready;
    assign pop      = beat && m_tlast;

    // queue pointers and beat index
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
            sub_reg    <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(Q_DEPTH - 1)) ? '0
                              : wr_ptr_reg + PTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(Q_DEPTH - 1)) ? '0
                              : rd_ptr_reg + PTR_W'(1);
                sub_reg    <= '0;
            end else if (beat) begin
                sub_reg <= sub_reg + CNT_W'(1);
            end
            if (push && !pop) begin
                level_reg <= level_reg + LEVEL_W'(1);
            end else if (pop && !push) begin
                level_reg <= level_reg - LEVEL_W'(1);
            end
        end
    end

    // entry storage
    always_ff @(posedge aclk) begin
        if (push) begin
            q_reg[wr_ptr_reg] <= item;
        end
    end

endmodule

// ===== rtl/core/gaussian_blur_5tap_rgb_pass.sv =====
// ---------------------------------------------------------------------------
// gaussian_blur_5tap_rgb_pass
// one horizontal or vertical pass of a symmetric 5-tap blur on rgb24 pixels
// ---------------------------------------------------------------------------
// Pixels enter in raster order, one beat per clock unless stalled, and
// leave in raster order lagging by two pixels (direction 0) or two rows
// (direction 1). Each pixel passes through the window stage with the
// line-store read, the multiply stage and the sum and clamp feeding a
// four-entry result queue. A pixel at the end of a row (direction 0), or any
// pixel of the last row (direction 1), causes three output beats, so there
// the output port sets the pace at one beat per clock and the input stalls
// once the result queue is full; everywhere else the sustained rate is one
// pixel per clock while the output is ready. The line store is four RAMs of
// MAX_WIDTH pixels; it is not cleared after reset and needs no clearing pass,
// every entry being written within a frame before its data is used. The user
// must write registers only while no pixel is in flight; this is not enforced.
module gaussian_blur_5tap_rgb_pass #(
    parameter int MAX_WIDTH = gblur_pkg::DEF_MAX_WIDTH
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    // input pixel stream
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [gblur_pkg::PIX_W-1:0]  s_tdata,   // red_in, green_in, blue_in
    // output pixel stream
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [gblur_pkg::PIX_W-1:0]  m_tdata,   // red_out, green_out, blue_out
    output logic                         m_tlast,   // run_last
    // register port
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [gblur_pkg::ADDR_W-1:0] paddr,
    input  logic [gblur_pkg::DATA_W-1:0] pwdata,
    output logic [gblur_pkg::DATA_W-1:0] prdata,
    output logic                         pready
);
    import gblur_pkg::*;

    cfg_t   cfg;
    tap_t   taps;
    item_t  item;
    logic   tap_valid;
    logic   take;
    logic   q_full;
    logic   push;

    gblur_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    gblur_window #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_window (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .s_valid   (s_tvalid),
        .s_pixel   (pixel_t'(s_tdata)),
        .s_ready   (s_tready),
        .take      (take),
        .tap_valid (tap_valid),
        .taps      (taps)
    );

    gblur_filter u_filter (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .tap_valid (tap_valid),
        .taps      (taps),
        .take      (take),
        .q_full    (q_full),
        .push      (push),
        .item      (item)
    );

    gblur_outq u_outq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .item     (item),
        .full     (q_full),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

// ===== rtl/core/gblur_checker.sv =====
// ---------------------------------------------------------------------------
// gblur_checker
// port-level checks of the blur pass, bound to the top level
// ---------------------------------------------------------------------------
`include "gaussian_blur_5tap_rgb_pass_defines.svh"

module gblur_checker (
    input logic                         aclk,
    input logic                         aresetn,
    input logic                         s_tready,
    input logic                         m_tvalid,
    input logic                         m_tready,
    input logic [gblur_pkg::PIX_W-1:0]  m_tdata,
    input logic                         m_tlast,
    input logic                         psel,
    input logic                         penable,
    input logic                         pwrite,
    input logic [gblur_pkg::ADDR_W-1:0] paddr,
    input logic [gblur_pkg::DATA_W-1:0] pwdata,
    input logic [gblur_pkg::DATA_W-1:0] prdata,
    input logic                         pready
);
    import gblur_pkg::*;

    // reset empties the result queue
    `GBLUR_ASSERT_RST(a_rst_no_out, !aresetn, !m_tvalid, "output valid right after reset")

    // a stalled output beat keeps its data
    `GBLUR_ASSERT_NXT(a_out_hold, m_tvalid && !m_tready,
        m_tvalid && $stable(m_tdata) && $stable(m_tlast), "stalled output beat changed")

    // with nothing waiting at the output the input never stalls
    `GBLUR_ASSERT_IMP(a_in_free, !m_tvalid, s_tready, "input stalled with empty output")

    // a direction write reads back
    `GBLUR_ASSERT_NXT(a_dir_readback,
        psel && penable && pwrite && pready && (paddr[ADDR_W-1:2] == REG_DIRECTION),
        (paddr[ADDR_W-1:2] == REG_DIRECTION) |-> (prdata[0] == $past(pwdata[0])),
        "direction register read back wrong")

endmodule

bind gaussian_blur_5tap_rgb_pass gblur_checker u_gblur_checker (.*);
